>>> design/protective_stop_controller_macros.svh
// Assertion macros shared by the protective stop controller RTL.
`ifndef PROTECTIVE_STOP_CONTROLLER_MACROS_SVH
`define PROTECTIVE_STOP_CONTROLLER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PSC_ASSERT_IMP(name, ante, cons, text) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(text);

// next-cycle implication, sampled on clk, off during rst
`define PSC_ASSERT_NXT(name, ante, cons, text) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(text);

`endif

>>> design/psc_pkg.sv
// Types and constants of the protective stop controller.
`default_nettype none
package psc_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] phase_t;
  typedef logic [2:0] resp_t;
  typedef logic [2:0] err_t;
  typedef logic [2:0] msg_code_t;

  localparam mode_t MODE_FREE      = 2'd0;
  localparam mode_t MODE_CONNECTED = 2'd1;
  localparam mode_t MODE_BONDED    = 2'd2;

  localparam phase_t PHASE_OK            = 2'd0;
  localparam phase_t PHASE_NEED_STOP     = 2'd1;
  localparam phase_t PHASE_STOP_RECEIVED = 2'd2;

  localparam resp_t RESP_NONE   = 3'd0;
  localparam resp_t RESP_BOND   = 3'd1;
  localparam resp_t RESP_UNBOND = 3'd2;
  localparam resp_t RESP_OK     = 3'd3;
  localparam resp_t RESP_STOP   = 3'd4;

  localparam err_t ERR_OK          = 3'd0;
  localparam err_t ERR_INVALID     = 3'd1;
  localparam err_t ERR_NOT_ALLOWED = 3'd2;
  localparam err_t ERR_NO_SPACE    = 3'd3;
  localparam err_t ERR_MISSED      = 3'd4;

  localparam msg_code_t CODE_BOND   = 3'd0;
  localparam msg_code_t CODE_UNBOND = 3'd1;
  localparam msg_code_t CODE_OK     = 3'd2;

  localparam logic FUNC_MESSAGE = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_IDX_LIMIT = 1'b0;

  localparam logic [15:0] LIMIT_RESET = 16'd3;

endpackage
`default_nettype wire

>>> design/psc_if.sv
// Request and result channel interfaces of the protective stop controller.
`default_nettype none
interface psc_msg_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] sender_id;
  logic [2:0]  message_code;
  logic        message_valid;
  logic [63:0] now_ms;
  logic        operator_allowed;
  logic        operator_stop_only;
  logic [15:0] operator_heartbeat_ms;

  modport source(output valid, func, sender_id, message_code, message_valid, now_ms,
                 operator_allowed, operator_stop_only, operator_heartbeat_ms,
                 input ready);
  modport sink(input valid, func, sender_id, message_code, message_valid, now_ms,
               operator_allowed, operator_stop_only, operator_heartbeat_ms,
               output ready);
endinterface

interface psc_resp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  response_code;
  logic [15:0] heartbeat_timeout_ms;
  logic [2:0]  error_code;
  logic        status_valid;
  logic        status_stop;
  logic        robot_stopped;

  modport source(output valid, response_code, heartbeat_timeout_ms, error_code,
                 status_valid, status_stop, robot_stopped, input ready);
  modport sink(input valid, response_code, heartbeat_timeout_ms, error_code,
               status_valid, status_stop, robot_stopped, output ready);
endinterface
`default_nettype wire

>>> design/psc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/psc_div.sv
// Restoring divider, 64-bit dividend by 16-bit divisor, one quotient bit a cycle.
`default_nettype none
module psc_div import psc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [16:0] rem_sh;
  logic [16:0] sub;
  logic        ge;

  // one restoring step
  always_comb begin
    rem_sh = {rem, dvd[63]};
    sub    = rem_sh - {1'b0, divisor};
    ge     = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
        quo  <= '0;
      end else if (busy) begin
        dvd <= {dvd[62:0], 1'b0};
        rem <= ge ? sub[15:0] : rem_sh[15:0];
        // only the low 16 quotient bits are kept
        quo <= {quo[14:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

>>> design/protective_stop_controller.sv
// Protective stop controller top level: remote table sequencer and robot stop state.
//
// Usage: requests enter on msg (valid/ready), one result per request leaves on
// resp (valid/ready). func 0 is a remote message (bond, unbond, ok, stop), func 1
// a heartbeat tick that frees every remote whose missed-period count reached
// missed_heartbeat_limit (APB register 0, reset 3).
// Slot data lives in one RAM of SLOT_COUNT entries, read one slot at a time
// through the S_RD and S_CHK states. A message scans the slots up to the matching
// one. A tick reads every slot, and each overdue slot with a nonzero period waits
// on the 64-step serial divider. One request is in work at a time.
// Reset frees every slot, sets the robot to stopped and the limit to 3; no
// clearing pass is needed since slot modes are flip-flops.
// A finished result sits in an output register; msg takes the next request while
// it waits. If resp is stalled when the following result is ready, the block
// holds that result and accepts nothing until the output register frees.
`default_nettype none
`include "protective_stop_controller_macros.svh"
module protective_stop_controller import psc_pkg::*; #(
  parameter int SLOT_COUNT = 8,
  parameter int ID_BITS    = 32
) (
  input  logic        clk,
  input  logic        rst,
  psc_msg_if.sink     msg,
  psc_resp_if.source  resp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdW  = (ID_BITS < 32) ? ID_BITS : 32;
  localparam int SlotW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OwnW = $clog2(SLOT_COUNT + 1);
  localparam int EntW = IdW + 1 + 16 + 64;
  localparam logic [SlotW-1:0] LastIdx = SlotW'(SLOT_COUNT - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_ACT  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // configuration
  logic [15:0] limit;
  logic        cfg_wr;

  // held request
  logic            it_func;
  logic [IdW-1:0]  it_id;
  msg_code_t       it_code;
  logic            it_valid;
  logic [63:0]     it_now;
  logic            it_allowed;
  logic            it_so;
  logic [15:0]     it_hb;

  // sequencer
  logic [2:0]       state;
  logic [SlotW-1:0] idx;
  logic             found;
  logic [SlotW-1:0] f_idx;
  logic             f_so;
  logic [15:0]      f_hb;
  logic             freed;

  // table and robot state
  mode_t            slot_mode [SLOT_COUNT];
  logic             stopped;
  phase_t           phase;
  logic [OwnW-1:0]  owner;

  // pending and output result
  resp_t       p_resp;
  logic [15:0] p_hb;
  err_t        p_err;
  logic        p_sv, p_ss, p_rs;
  logic        o_valid;
  resp_t       o_resp;
  logic [15:0] o_hb;
  err_t        o_err;
  logic        o_sv, o_ss, o_rs;

  // RAM and divider
  logic             ram_we;
  logic [EntW-1:0]  ram_wdata;
  logic [EntW-1:0]  ram_rdata;
  logic             div_start;
  logic             div_done;
  logic [15:0]      div_q;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_LIMIT);
  assign prdata = (paddr[2] == REG_IDX_LIMIT) ? {16'd0, limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_wr) begin
      limit <= pwdata[15:0];
    end
  end

  // slot entry fields
  logic [IdW-1:0] e_id;
  logic           e_so;
  logic [15:0]    e_hb;
  logic [63:0]    e_last;
  logic           e_busy;
  logic           e_match;
  logic           e_overdue;
  logic [63:0]    e_diff;
  logic           last_slot;

  always_comb begin
    e_id      = ram_rdata[EntW-1 -: IdW];
    e_so      = ram_rdata[80];
    e_hb      = ram_rdata[79:64];
    e_last    = ram_rdata[63:0];
    e_busy    = slot_mode[idx] != MODE_FREE;
    e_match   = e_busy && (e_id == it_id);
    e_diff    = it_now - e_last;
    e_overdue = e_busy && (it_now > e_last) && (e_diff > {48'd0, e_hb});
    last_slot = idx == LastIdx;
  end

  assign div_start = (state == S_CHK) && (it_func == FUNC_TICK) && e_overdue &&
                     (e_hb != 16'd0);

  // busy-slot vector and lowest free slot
  logic [SLOT_COUNT-1:0] nf;
  logic                  free_found;
  logic [SlotW-1:0]      free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      nf[i] = slot_mode[i] != MODE_FREE;
      if (slot_mode[i] == MODE_FREE) begin
        free_found = 1'b1;
        free_idx   = SlotW'(i);
      end
    end
  end

  // request action on the chosen slot
  resp_t                 a_resp;
  logic [15:0]           a_hb;
  err_t                  a_err;
  logic                  a_sv, a_ss;
  logic                  n_st;
  phase_t                n_ph;
  logic [OwnW-1:0]       n_ow;
  logic [SlotW-1:0]      a_s;
  logic                  a_has, a_new, a_so;
  logic [15:0]           a_hbs;
  logic                  a_mode_we;
  mode_t                 a_mode, cur;
  logic [OwnW-1:0]       s_own;
  logic [SLOT_COUNT-1:0] oh;

  always_comb begin
    a_resp    = RESP_NONE;
    a_hb      = 16'd0;
    a_err     = ERR_OK;
    a_sv      = 1'b0;
    a_ss      = 1'b0;
    n_st      = stopped;
    n_ph      = phase;
    n_ow      = owner;
    a_s       = found ? f_idx : free_idx;
    a_has     = 1'b0;
    a_new     = 1'b0;
    a_so      = found ? f_so : it_so;
    a_hbs     = found ? f_hb : it_hb;
    a_mode_we = 1'b0;
    a_mode    = MODE_FREE;
    s_own     = OwnW'(a_s) + OwnW'(1);
    oh        = '0;
    oh[a_s]   = 1'b1;
    cur       = slot_mode[a_s];
    if (it_func == FUNC_TICK) begin
      a_sv = 1'b1;
      if (freed) begin
        n_st  = 1'b1;
        n_ph  = PHASE_NEED_STOP;
        n_ow  = '0;
        a_ss  = 1'b1;
        a_err = ERR_MISSED;
      end else begin
        a_ss = stopped;
      end
    end else if (!it_valid) begin
      a_err = ERR_INVALID;
    end else begin
      if (!found) begin
        if (it_code != CODE_BOND) begin
          a_resp = RESP_UNBOND;
        end else if (!it_allowed) begin
          a_resp = RESP_UNBOND;
          a_err  = ERR_NOT_ALLOWED;
        end else if (!free_found) begin
          a_resp = RESP_UNBOND;
          a_err  = ERR_NO_SPACE;
        end else begin
          a_has = 1'b1;
          a_new = 1'b1;
        end
      end else begin
        a_has = 1'b1;
      end
      if (a_has) begin
        a_hb = a_hbs;
        if (a_new) begin
          cur = MODE_CONNECTED;
        end
        case (it_code)
          CODE_BOND: begin
            a_resp    = RESP_BOND;
            a_mode_we = 1'b1;
            a_mode    = MODE_BONDED;
            // first active remote restarts the stop cycle
            if (cur != MODE_BONDED && $countones(nf | oh) == 1) begin
              n_ph = PHASE_NEED_STOP;
              n_ow = '0;
              n_st = 1'b1;
            end
          end
          CODE_UNBOND: begin
            a_resp    = RESP_UNBOND;
            a_mode_we = 1'b1;
            a_mode    = MODE_FREE;
            if (owner == s_own) begin
              n_st = 1'b1;
            end
            if ((nf & ~oh) == '0 || n_st) begin
              n_st = 1'b1;
              n_ph = PHASE_NEED_STOP;
              n_ow = '0;
              a_sv = 1'b1;
              a_ss = 1'b1;
            end else if (owner == s_own) begin
              n_ph = PHASE_NEED_STOP;
              n_ow = '0;
            end
          end
          CODE_OK: begin
            if (phase == PHASE_NEED_STOP) begin
              a_resp = RESP_STOP;
            end else if (owner != s_own) begin
              a_resp = stopped ? RESP_STOP : RESP_OK;
            end else begin
              a_resp = RESP_OK;
              n_st   = 1'b0;
              n_ph   = PHASE_OK;
              a_sv   = 1'b1;
            end
          end
          default: begin
            // stop and every unknown code
            a_resp = RESP_STOP;
            a_sv   = 1'b1;
            a_ss   = 1'b1;
            if (owner == '0) begin
              if (!a_so) begin
                n_st = 1'b1;
                n_ow = s_own;
                n_ph = PHASE_STOP_RECEIVED;
              end
            end else begin
              n_st = 1'b1;
              if (!a_so) begin
                n_ow = s_own;
                n_ph = PHASE_STOP_RECEIVED;
              end else begin
                n_ow = '0;
              end
            end
          end
        endcase
      end
    end
  end

  assign ram_we    = (state == S_ACT) && a_has;
  assign ram_wdata = {it_id, a_so, a_hbs, it_now};

  psc_ram #(
    .WIDTH (EntW),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_s),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  psc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (e_diff),
    .divisor  (e_hb),
    .done     (div_done),
    .quotient (div_q)
  );

  assign msg.ready = state == S_IDLE;

  // sequencer, table and robot state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      found   <= 1'b0;
      freed   <= 1'b0;
      stopped <= 1'b1;
      phase   <= PHASE_OK;
      owner   <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_mode[i] <= MODE_FREE;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (msg.valid) begin
            it_func    <= msg.func;
            it_id      <= msg.sender_id[IdW-1:0];
            it_code    <= msg.message_code;
            it_valid   <= msg.message_valid;
            it_now     <= msg.now_ms;
            it_allowed <= msg.operator_allowed;
            it_so      <= msg.operator_stop_only;
            it_hb      <= msg.operator_heartbeat_ms;
            idx        <= '0;
            found      <= 1'b0;
            freed      <= 1'b0;
            if (msg.func == FUNC_MESSAGE && !msg.message_valid) begin
              state <= S_ACT;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (it_func == FUNC_MESSAGE) begin
            if (e_match) begin
              found <= 1'b1;
              f_idx <= idx;
              f_so  <= e_so;
              f_hb  <= e_hb;
              state <= S_ACT;
            end else if (last_slot) begin
              state <= S_ACT;
            end else begin
              idx   <= idx + SlotW'(1);
              state <= S_RD;
            end
          end else if (div_start) begin
            state <= S_DIV;
          end else begin
            // zero period counts as the largest miss count
            if (e_overdue) begin
              slot_mode[idx] <= MODE_FREE;
              freed          <= 1'b1;
            end
            if (last_slot) begin
              state <= S_ACT;
            end else begin
              idx   <= idx + SlotW'(1);
              state <= S_RD;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_q >= limit) begin
              slot_mode[idx] <= MODE_FREE;
              freed          <= 1'b1;
            end
            if (last_slot) begin
              state <= S_ACT;
            end else begin
              idx   <= idx + SlotW'(1);
              state <= S_RD;
            end
          end
        end
        S_ACT: begin
          if (a_mode_we) begin
            slot_mode[a_s] <= a_mode;
          end
          stopped <= n_st;
          phase   <= n_ph;
          owner   <= n_ow;
          p_resp  <= a_resp;
          p_hb    <= a_hb;
          p_err   <= a_err;
          p_sv    <= a_sv;
          p_ss    <= a_ss;
          p_rs    <= n_st;
          state   <= S_OUT;
        end
        S_OUT: begin
          if (!o_valid || resp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!o_valid || resp.ready)) begin
        o_valid <= 1'b1;
        o_resp  <= p_resp;
        o_hb    <= p_hb;
        o_err   <= p_err;
        o_sv    <= p_sv;
        o_ss    <= p_ss;
        o_rs    <= p_rs;
      end else if (o_valid && resp.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign resp.valid                = o_valid;
  assign resp.response_code        = o_resp;
  assign resp.heartbeat_timeout_ms = o_hb;
  assign resp.error_code           = o_err;
  assign resp.status_valid         = o_sv;
  assign resp.status_stop          = o_ss;
  assign resp.robot_stopped        = o_rs;

  `PSC_ASSERT_IMP(a_need_stop_no_owner, phase == PHASE_NEED_STOP, owner == '0, "owner set while a stop is needed")
  `PSC_ASSERT_IMP(a_need_stop_stopped, phase == PHASE_NEED_STOP, stopped, "robot running while a stop is needed")
  `PSC_ASSERT_NXT(a_accept_leaves_idle, msg.valid && msg.ready, state != S_IDLE, "sequencer idle after accepting a request")
  `PSC_ASSERT_IMP(a_div_done_in_div, div_done, state == S_DIV, "divider result outside the divide wait")

endmodule
`default_nettype wire

>>> verif/protective_stop_controller_checker.sv
// Result checker of the protective stop controller: predicts every response and compares it.
`timescale 1ns / 1ps
`default_nettype none
module protective_stop_controller_checker import psc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  psc_msg_if          msg,
  psc_resp_if         resp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          outstanding,
  output int          compared
);

  localparam int SLOTS = 8;

  typedef struct packed {
    resp_t       response_code;
    logic [15:0] heartbeat_timeout_ms;
    err_t        error_code;
    logic        status_valid;
    logic        status_stop;
    logic        robot_stopped;
  } answer_t;

  // shadow copy of the controller state
  mode_t       mode_q [SLOTS];
  logic [31:0] id_q [SLOTS];
  logic        stop_only_q [SLOTS];
  logic [15:0] period_q [SLOTS];
  logic [63:0] heard_q [SLOTS];
  logic        stopped_q;
  phase_t      phase_q;
  logic [3:0]  owner_q;
  logic [15:0] limit_q;
  logic        note_valid;
  logic        note_stop;

  answer_t expected_answers [$];
  int      bad;
  int      seen;

  function automatic int active_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++)
      if (mode_q[i] != MODE_FREE) n++;
    return n;
  endfunction

  task automatic halt_robot();
    stopped_q = 1'b1;
    phase_q = PHASE_NEED_STOP;
    owner_q = 4'd0;
    note_valid = 1'b1;
    note_stop = 1'b1;
  endtask

  // apply one request to the shadow state and work out its answer
  task automatic predict_answer(output answer_t a);
    logic [63:0] diff;
    logic [15:0] missed;
    logic        freed;
    int          s;
    a = '0;
    note_valid = 1'b0;
    note_stop = 1'b0;
    if (msg.func == FUNC_TICK) begin
      freed = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (mode_q[i] != MODE_FREE && msg.now_ms > heard_q[i]) begin
          diff = msg.now_ms - heard_q[i];
          if (diff > {48'd0, period_q[i]}) begin
            if (period_q[i] == 16'd0) missed = 16'hFFFF;
            else missed = 16'(diff / {48'd0, period_q[i]});
            if (missed >= limit_q) begin
              mode_q[i] = MODE_FREE;
              freed = 1'b1;
            end
          end
        end
      end
      if (freed) begin
        halt_robot();
        a.error_code = ERR_MISSED;
      end else begin
        note_valid = 1'b1;
        note_stop = stopped_q;
      end
    end else if (!msg.message_valid) begin
      a.error_code = ERR_INVALID;
    end else begin
      s = SLOTS;
      for (int i = 0; i < SLOTS; i++)
        if (s == SLOTS && mode_q[i] != MODE_FREE && id_q[i] == msg.sender_id) s = i;
      if (s == SLOTS) begin
        a.response_code = RESP_UNBOND;
        if (msg.message_code == CODE_BOND) begin
          if (!msg.operator_allowed) begin
            a.error_code = ERR_NOT_ALLOWED;
          end else begin
            for (int i = 0; i < SLOTS; i++)
              if (s == SLOTS && mode_q[i] == MODE_FREE) s = i;
            if (s == SLOTS) begin
              a.error_code = ERR_NO_SPACE;
            end else begin
              mode_q[s] = MODE_CONNECTED;
              stop_only_q[s] = msg.operator_stop_only;
              period_q[s] = msg.operator_heartbeat_ms;
              id_q[s] = msg.sender_id;
            end
          end
        end
      end
      if (s < SLOTS) begin
        a.heartbeat_timeout_ms = period_q[s];
        heard_q[s] = msg.now_ms;
        case (msg.message_code)
          CODE_BOND: begin
            a.response_code = RESP_BOND;
            if (mode_q[s] != MODE_BONDED) begin
              mode_q[s] = MODE_BONDED;
              if (active_slots() == 1) begin
                phase_q = PHASE_NEED_STOP;
                owner_q = 4'd0;
                stopped_q = 1'b1;
              end
            end
          end
          CODE_UNBOND: begin
            a.response_code = RESP_UNBOND;
            if (owner_q == 4'(s + 1)) begin
              phase_q = PHASE_NEED_STOP;
              owner_q = 4'd0;
              stopped_q = 1'b1;
            end
            mode_q[s] = MODE_FREE;
            if (active_slots() == 0 || stopped_q) halt_robot();
          end
          CODE_OK: begin
            if (phase_q == PHASE_NEED_STOP) begin
              a.response_code = RESP_STOP;
            end else if (owner_q != 4'(s + 1)) begin
              a.response_code = stopped_q ? RESP_STOP : RESP_OK;
            end else begin
              stopped_q = 1'b0;
              phase_q = PHASE_OK;
              note_valid = 1'b1;
              note_stop = 1'b0;
              a.response_code = RESP_OK;
            end
          end
          default: begin
            // any other code is a stop; a stop-only remote never takes ownership
            if (owner_q == 4'd0) begin
              if (!stop_only_q[s]) begin
                stopped_q = 1'b1;
                owner_q = 4'(s + 1);
                phase_q = PHASE_STOP_RECEIVED;
              end
            end else begin
              stopped_q = 1'b1;
              if (!stop_only_q[s]) begin
                owner_q = 4'(s + 1);
                phase_q = PHASE_STOP_RECEIVED;
              end else begin
                owner_q = 4'd0;
              end
            end
            note_valid = 1'b1;
            note_stop = 1'b1;
            a.response_code = RESP_STOP;
          end
        endcase
      end
    end
    a.status_valid = note_valid;
    a.status_stop = note_stop;
    a.robot_stopped = stopped_q;
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        mode_q[i] = MODE_FREE;
        id_q[i] = '0;
        stop_only_q[i] = 1'b0;
        period_q[i] = '0;
        heard_q[i] = '0;
      end
      stopped_q = 1'b1;
      phase_q = PHASE_OK;
      owner_q = 4'd0;
      limit_q = LIMIT_RESET;
      expected_answers.delete();
      bad = 0;
      seen = 0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_IDX_LIMIT)
        limit_q = pwdata[15:0];
      if (msg.valid && msg.ready) begin
        predict_answer(want);
        expected_answers.push_back(want);
      end
      if (resp.valid && resp.ready) begin
        if (expected_answers.size() == 0) begin
          $error("response with no request waiting");
          bad++;
        end else begin
          want = expected_answers.pop_front();
          seen++;
          if (resp.response_code !== want.response_code) begin
            $error("response_code: expected %0d, got %0d", want.response_code,
                   resp.response_code);
            bad++;
          end
          if (resp.heartbeat_timeout_ms !== want.heartbeat_timeout_ms) begin
            $error("heartbeat_timeout_ms: expected %0d, got %0d",
                   want.heartbeat_timeout_ms, resp.heartbeat_timeout_ms);
            bad++;
          end
          if (resp.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, resp.error_code);
            bad++;
          end
          if (resp.status_valid !== want.status_valid) begin
            $error("status_valid: expected %0d, got %0d", want.status_valid,
                   resp.status_valid);
            bad++;
          end
          if (resp.status_stop !== want.status_stop) begin
            $error("status_stop: expected %0d, got %0d", want.status_stop, resp.status_stop);
            bad++;
          end
          if (resp.robot_stopped !== want.robot_stopped) begin
            $error("robot_stopped: expected %0d, got %0d", want.robot_stopped,
                   resp.robot_stopped);
            bad++;
          end
        end
      end
    end
    mismatch_count <= bad;
    outstanding <= expected_answers.size();
    compared <= seen;
  end

endmodule
`default_nettype wire

>>> verif/protective_stop_controller_test.sv
// Testbench top of the protective stop controller: stimulus, register writes and verdict.
`timescale 1ns / 1ps
`default_nettype none
module protective_stop_controller_test;
  import psc_pkg::*;

  localparam int POOL = 12;
  localparam int SETTLE = 600;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          outstanding;
  int          compared;
  int          sent;
  int          settings;
  logic        calm;
  logic [63:0] clock_ms;
  logic [31:0] id_pool [POOL];

  psc_msg_if  msg_ch ();
  psc_resp_if resp_ch ();

  protective_stop_controller dut (
    .clk(clk), .rst(rst), .msg(msg_ch), .resp(resp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  protective_stop_controller_checker checker_inst (
    .clk(clk), .rst(rst), .msg(msg_ch), .resp(resp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .outstanding(outstanding), .compared(compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("** protective_stop_controller: FAILED **");
    $finish;
  end

  // result side: random stall before each result, none while calm
  initial begin
    int gap;
    resp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        resp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      resp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(resp_ch.valid && resp_ch.ready));
    end
  end

  // offer one request after a random gap and hold it until taken
  task automatic send_request(input logic f, input logic [31:0] id, input msg_code_t code,
                              input logic mv, input logic [63:0] now, input logic al,
                              input logic so, input logic [15:0] hb);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      msg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_ch.valid <= 1'b1;
    msg_ch.func <= f;
    msg_ch.sender_id <= id;
    msg_ch.message_code <= code;
    msg_ch.message_valid <= mv;
    msg_ch.now_ms <= now;
    msg_ch.operator_allowed <= al;
    msg_ch.operator_stop_only <= so;
    msg_ch.operator_heartbeat_ms <= hb;
    do @(posedge clk); while (!(msg_ch.valid && msg_ch.ready));
    sent++;
  endtask

  task automatic drain();
    msg_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_IDX_LIMIT, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    settings++;
  endtask

  // one random request, mostly from a small set of known remotes
  task automatic random_request();
    int          r;
    msg_code_t   code;
    logic [31:0] id;
    logic [63:0] now;
    logic [15:0] hb;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) clock_ms += 64'($urandom_range(0, 200000));
    else clock_ms += 64'($urandom_range(0, 30));
    now = clock_ms;
    if ($urandom_range(0, 33) == 0) now = clock_ms - 64'($urandom_range(1, 100));
    if ($urandom_range(0, 49) == 0) now = {$urandom, $urandom};
    id = ($urandom_range(0, 19) == 0) ? $urandom : id_pool[$urandom_range(0, POOL - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2: code = CODE_BOND;
      3: code = CODE_UNBOND;
      4, 5, 6: code = CODE_OK;
      default: code = msg_code_t'($urandom_range(3, 7));
    endcase
    hb = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                     : 16'($urandom_range(1, 40));
    send_request(r < 12 ? FUNC_TICK : FUNC_MESSAGE, id, code, $urandom_range(0, 19) != 0,
                 now, $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0, hb);
  endtask

  initial begin
    logic [15:0] limits [5];
    rst = 1'b1;
    calm = 1'b0;
    sent = 0;
    settings = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    msg_ch.valid = 1'b0;
    msg_ch.func = FUNC_MESSAGE;
    msg_ch.sender_id = '0;
    msg_ch.message_code = CODE_BOND;
    msg_ch.message_valid = 1'b0;
    msg_ch.now_ms = '0;
    msg_ch.operator_allowed = 1'b0;
    msg_ch.operator_stop_only = 1'b0;
    msg_ch.operator_heartbeat_ms = 16'd1;
    for (int i = 0; i < POOL; i++) id_pool[i] = $urandom;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset state, refusals, ownership cycle, full table, timeouts
    send_request(FUNC_TICK, 32'd0, CODE_BOND, 1'b1, 64'd100, 1'b0, 1'b0, 16'd1);
    send_request(FUNC_MESSAGE, 32'h5, CODE_BOND, 1'b0, 64'd100, 1'b1, 1'b0, 16'd10);
    send_request(FUNC_MESSAGE, 32'h5, CODE_OK, 1'b1, 64'd100, 1'b1, 1'b0, 16'd10);
    send_request(FUNC_MESSAGE, 32'h5, CODE_BOND, 1'b1, 64'd100, 1'b0, 1'b0, 16'd10);
    send_request(FUNC_MESSAGE, 32'hFFFF_FFFF, CODE_BOND, 1'b1, 64'd100, 1'b1, 1'b0, 16'hFFFF);
    send_request(FUNC_MESSAGE, 32'hFFFF_FFFF, CODE_OK, 1'b1, 64'd101, 1'b1, 1'b0, 16'd1);
    send_request(FUNC_MESSAGE, 32'hFFFF_FFFF, msg_code_t'(3), 1'b1, 64'd102, 1'b1, 1'b0, 16'd1);
    send_request(FUNC_MESSAGE, 32'hFFFF_FFFF, CODE_OK, 1'b1, 64'd103, 1'b1, 1'b0, 16'd1);
    send_request(FUNC_MESSAGE, 32'h0, CODE_BOND, 1'b1, 64'd104, 1'b1, 1'b1, 16'd0);
    send_request(FUNC_MESSAGE, 32'h0, msg_code_t'(7), 1'b1, 64'd105, 1'b1, 1'b0, 16'd1);
    for (int i = 1; i <= 7; i++)
      send_request(FUNC_MESSAGE, 32'(i * 32'h1111_1111), CODE_BOND, 1'b1, 64'd106, 1'b1,
                   i[0], 16'(i * 5));
    send_request(FUNC_MESSAGE, 32'hABCD, msg_code_t'(5), 1'b1, 64'd107, 1'b1, 1'b0, 16'd1);
    send_request(FUNC_TICK, 32'd0, CODE_BOND, 1'b1, 64'd50, 1'b0, 1'b0, 16'd1);
    send_request(FUNC_MESSAGE, 32'h0, CODE_UNBOND, 1'b1, 64'd108, 1'b1, 1'b0, 16'd1);
    send_request(FUNC_TICK, 32'd0, CODE_BOND, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1,
                 16'hFFFF);
    send_request(FUNC_MESSAGE, 32'h5, msg_code_t'(6), 1'b1, 64'd0, 1'b1, 1'b0, 16'd1);

    // random phases over several limits, the extremes among them
    limits[0] = 16'd1;
    limits[1] = 16'd0;
    limits[2] = 16'hFFFF;
    limits[3] = LIMIT_RESET;
    limits[4] = 16'($urandom_range(2, 40));
    clock_ms = 64'hFFFF_FFFF_0000_0000 - 64'($urandom_range(0, 1000000));
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      for (int k = 0; k < 136; k++) begin
        if (k % 40 == 0) calm = $urandom_range(0, 2) == 0;
        random_request();
      end
    end
    calm = 1'b0;

    drain();
    $display("Covered %0d requests under %0d limit settings; %0d results compared.",
             sent, settings, compared);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** protective_stop_controller: PASSED **");
    end else begin
      $display("** protective_stop_controller: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> protective_stop_controller.f
+incdir+design
design/psc_pkg.sv
design/psc_if.sv
design/psc_ram.sv
design/psc_div.sv
design/protective_stop_controller.sv
verif/protective_stop_controller_checker.sv
verif/protective_stop_controller_test.sv
